/* hdl/lmt_pkg.sv */
// Shared constants and types for the lambda maximal segment tangent block.
// No dependencies; imported by every other module in hdl/.
package lmt_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ANG_W      = 16;
  localparam int WSUM_W     = 23;
  localparam int ASUM_W     = 38;
  localparam int DVD_W      = 53;
  localparam int DVS_W      = 36;
  localparam int QUO_W      = 17;
  localparam int QCNT_W     = 5;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic                    seg_ok;
    logic [IDX_W-1:0]        seg_end;
    logic signed [ANG_W-1:0] angle;
    logic                    fin;
  } pt_rec_t;

endpackage

/* hdl/lmt_front.sv */
// Front end: accepts curve points, numbers them and classifies segments.
// Depends on lmt_pkg; feeds lmt_queue.
module lmt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 has_segment_i,
  input  logic [5:0]           segment_end_i,
  input  logic signed [15:0]   segment_angle_i,
  input  logic                 last_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output lmt_pkg::pt_rec_t     q_rec_o
);
  import lmt_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             fin;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign fin        = last_i || (idx_q == IDX_W'(MAX_POINTS - 1));

  always_comb begin
    q_rec_o.idx     = idx_q;
    q_rec_o.seg_ok  = has_segment_i && (segment_end_i > idx_q);
    q_rec_o.seg_end = segment_end_i;
    q_rec_o.angle   = segment_angle_i;
    q_rec_o.fin     = fin;
    idx_d           = idx_q;
    if (q_push_o) begin
      idx_d = fin ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* hdl/lmt_queue.sv */
// Two-entry queue of point requests between front and back end.
// Depends on lmt_pkg.
module lmt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lmt_pkg::pt_rec_t rec_i,
  output logic             full_o,
  input  logic             pop_i,
  output lmt_pkg::pt_rec_t rec_o,
  output logic             empty_o
);
  import lmt_pkg::*;

  pt_rec_t    ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rec_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* hdl/lmt_div.sv */
// Restoring divider, one quotient bit per cycle, shared by weight and mean.
// Depends on lmt_pkg.
module lmt_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lmt_pkg::DVD_W-1:0]    dividend_i,
  input  logic [lmt_pkg::DVS_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [lmt_pkg::QUO_W-1:0]    quot_o
);
  import lmt_pkg::*;

  logic [DVD_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [QUO_W-1:0]  quo_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DVD_W-1:0]  sh;
  logic              ge;

  assign sh     = {{(DVD_W-DVS_W){1'b0}}, dvs_q} << cnt_q;
  assign ge     = rem_q >= sh;
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - sh;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= QCNT_W'(QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/lmt_back.sv */
// Back end: stores points, accumulates lambda weights and emits directions.
// Depends on lmt_pkg and lmt_div.
module lmt_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  lmt_pkg::pt_rec_t     q_rec_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   direction_o,
  output logic                 last_res_o
);
  import lmt_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_CLR, S_SREAD, S_SCHK, S_SNEXT, S_WMUL1, S_WMUL2, S_WMUL3,
    S_WDIV, S_WWAIT, S_WACC, S_ZERO, S_QREAD, S_QCHK, S_QWAIT, S_QMIX, S_QOUT
  } state_e;

  function automatic logic signed [ANG_W-1:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767)       return 16'sh7FFF;
    else if (v < -19'sd32768) return 16'sh8000;
    else                      return v[ANG_W-1:0];
  endfunction

  logic [IDX_W:0]          se_mem [MAX_POINTS];
  logic [ANG_W-1:0]        ang_mem [MAX_POINTS];
  logic [WSUM_W-1:0]       ws_mem [MAX_POINTS];
  logic [ASUM_W-1:0]       as_mem [MAX_POINTS];
  logic [IDX_W:0]          se_rd_q;
  logic signed [ANG_W-1:0] ang_rd_q;
  logic [WSUM_W-1:0]       ws_rd_q;
  logic signed [ASUM_W-1:0] as_rd_q;

  state_e                  state_q;
  logic [CNT_W-1:0]        n_q;
  logic [IDX_W-1:0]        i_q, k_q, kend_q, e_q, pos_q;
  logic signed [ANG_W-1:0] ang_q, dir_q;
  logic [11:0]             p_q, d2_q;
  logic [23:0]             p2_q;
  logic [17:0]             d3_q;
  logic [35:0]             p3_q, d6_q;
  logic                    use_next_q, neg_q;
  logic signed [17:0]      nq_q;
  logic                    out_valid_q, last_q;
  logic signed [ANG_W-1:0] out_dir_q;

  logic                    div_start, div_done;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic [QUO_W-1:0]        div_quo;

  logic [IDX_W-1:0]        nm1, a_w, d_w, b_w, target, sum_ra;
  logic                    se_we, sum_we, seg_re, sum_re, out_free, out_emit;
  logic [WSUM_W-1:0]       ws_wd;
  logic [ASUM_W-1:0]       as_wd, mag;
  logic signed [33:0]      prod;
  logic signed [17:0]      qs;
  logic signed [18:0]      s_w, h_w;

  lmt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  assign nm1      = IDX_W'(n_q - 1'b1);
  assign a_w      = k_q - i_q;
  assign d_w      = e_q - i_q;
  assign b_w      = d_w - a_w;
  assign target   = (k_q == nm1 - 1'b1) ? nm1 : k_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_emit = out_free && ((state_q == S_ZERO) || (state_q == S_QOUT));
  assign q_pop_o  = (state_q == S_LOAD) && !q_empty_i;
  assign se_we    = q_pop_o;
  assign seg_re   = (state_q == S_SREAD);
  assign prod     = $signed({1'b0, div_quo}) * ang_q;
  assign mag      = as_rd_q[ASUM_W-1] ? ASUM_W'(-as_rd_q) : as_rd_q;
  assign qs       = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign s_w      = {{3{dir_q[ANG_W-1]}}, dir_q} + {nq_q[17], nq_q};
  assign h_w      = s_w[18] ? -((-s_w + 19'sd1) >>> 1) : ((s_w + 19'sd1) >>> 1);

  always_comb begin
    sum_we    = 1'b0;
    sum_re    = 1'b0;
    sum_ra    = k_q;
    ws_wd     = '0;
    as_wd     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_q)
      S_CLR: sum_we = 1'b1;
      S_WDIV: begin
        sum_re    = 1'b1;
        div_start = 1'b1;
        div_dvd   = {p3_q[30:0], 22'b0} + ({{(DVD_W-DVS_W){1'b0}}, d6_q} >> 1);
        div_dvs   = d6_q;
      end
      S_WACC: begin
        sum_we = 1'b1;
        ws_wd  = ws_rd_q + {{(WSUM_W-QUO_W){1'b0}}, div_quo};
        as_wd  = as_rd_q + {{(ASUM_W-34){prod[33]}}, prod};
      end
      S_QREAD: begin
        sum_re = 1'b1;
        sum_ra = k_q + {{(IDX_W-1){1'b0}}, use_next_q};
      end
      S_QCHK: begin
        div_start = (ws_rd_q != '0);
        div_dvd   = {{(DVD_W-ASUM_W){1'b0}}, mag}
                  + ({{(DVD_W-WSUM_W){1'b0}}, ws_rd_q} >> 1);
        div_dvs   = {{(DVS_W-WSUM_W){1'b0}}, ws_rd_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (se_we) begin
      se_mem[q_rec_i.idx]  <= {q_rec_i.seg_ok, q_rec_i.seg_end};
      ang_mem[q_rec_i.idx] <= q_rec_i.angle;
    end
    if (seg_re) begin
      se_rd_q  <= se_mem[i_q];
      ang_rd_q <= ang_mem[i_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      ws_mem[k_q] <= ws_wd;
      as_mem[k_q] <= as_wd;
    end
    if (sum_re) begin
      ws_rd_q <= ws_mem[sum_ra];
      as_rd_q <= as_mem[sum_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      n_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      kend_q      <= '0;
      e_q         <= '0;
      pos_q       <= '0;
      ang_q       <= '0;
      dir_q       <= '0;
      p_q         <= '0;
      d2_q        <= '0;
      p2_q        <= '0;
      d3_q        <= '0;
      p3_q        <= '0;
      d6_q        <= '0;
      use_next_q  <= 1'b0;
      neg_q       <= 1'b0;
      nq_q        <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      out_dir_q   <= '0;
    end else begin
      if (out_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (q_pop_o && q_rec_i.fin) begin
            n_q     <= {1'b0, q_rec_i.idx} + 1'b1;
            k_q     <= '0;
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          if (k_q == nm1) begin
            i_q     <= '0;
            state_q <= S_SREAD;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_SREAD: state_q <= S_SCHK;
        S_SCHK: begin
          if (se_rd_q[IDX_W]) begin
            e_q     <= se_rd_q[IDX_W-1:0];
            kend_q  <= (se_rd_q[IDX_W-1:0] > nm1) ? nm1 : se_rd_q[IDX_W-1:0];
            k_q     <= i_q;
            ang_q   <= ang_rd_q;
            state_q <= S_WMUL1;
          end else begin
            state_q <= S_SNEXT;
          end
        end
        S_SNEXT: begin
          if (i_q == nm1) begin
            pos_q      <= '0;
            dir_q      <= '0;
            k_q        <= IDX_W'(1);
            use_next_q <= 1'b0;
            state_q    <= (n_q < CNT_W'(3)) ? S_ZERO : S_QREAD;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SREAD;
          end
        end
        S_WMUL1: begin
          p_q     <= a_w * b_w;
          d2_q    <= d_w * d_w;
          state_q <= S_WMUL2;
        end
        S_WMUL2: begin
          p2_q    <= p_q * p_q;
          d3_q    <= d2_q * d_w;
          state_q <= S_WMUL3;
        end
        S_WMUL3: begin
          p3_q    <= p2_q * p_q;
          d6_q    <= d3_q * d3_q;
          state_q <= S_WDIV;
        end
        S_WDIV: state_q <= S_WWAIT;
        S_WWAIT: begin
          if (div_done) state_q <= S_WACC;
        end
        S_WACC: begin
          if (k_q == kend_q) begin
            state_q <= S_SNEXT;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_WMUL1;
          end
        end
        S_ZERO: begin
          if (out_free) begin
            out_dir_q   <= '0;
            last_q      <= (pos_q == nm1);
            pos_q       <= pos_q + 1'b1;
            if (pos_q == nm1) state_q <= S_LOAD;
          end
        end
        S_QREAD: state_q <= S_QCHK;
        S_QCHK: begin
          if (ws_rd_q != '0) begin
            neg_q   <= as_rd_q[ASUM_W-1];
            state_q <= S_QWAIT;
          end else if (!use_next_q) begin
            use_next_q <= 1'b1;
            state_q    <= S_QREAD;
          end else begin
            nq_q    <= '0;
            state_q <= S_QMIX;
          end
        end
        S_QWAIT: begin
          if (div_done) begin
            if (!use_next_q) begin
              dir_q   <= sat16({qs[17], qs});
              state_q <= S_QOUT;
            end else begin
              nq_q    <= qs;
              state_q <= S_QMIX;
            end
          end
        end
        S_QMIX: begin
          dir_q   <= sat16(h_w);
          state_q <= S_QOUT;
        end
        S_QOUT: begin
          if (out_free) begin
            out_dir_q   <= dir_q;
            last_q      <= (pos_q == nm1);
            pos_q       <= pos_q + 1'b1;
            if (pos_q == target) begin
              if (k_q == nm1 - 1'b1) begin
                state_q <= S_LOAD;
              end else begin
                k_q        <= k_q + 1'b1;
                use_next_q <= 1'b0;
                state_q    <= S_QREAD;
              end
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign direction_o = out_dir_q;
  assign last_res_o  = last_q;

endmodule

/* hdl/lambda_mst_tangent_2d.sv */
// Lambda maximal segment tangent estimator, top level.
// Points load through a two-entry queue that stalls the input while full; on
// the last point the back end clears n sums, then runs the weight multiply
// chain and the divider for each covered position of each segment, derives
// each inner direction from the sums (using the next position if needed),
// with n results. Reset is asynchronous, active low, and returns to loading.
module lambda_mst_tangent_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               has_segment_i,
  input  logic [5:0]         segment_end_i,
  input  logic signed [15:0] segment_angle_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] direction_o,
  output logic               last_res_o
);
  import lmt_pkg::*;

  pt_rec_t push_rec, pop_rec;
  logic    q_push, q_pop, q_full, q_empty;

  lmt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .has_segment_i   (has_segment_i),
    .segment_end_i   (segment_end_i),
    .segment_angle_i (segment_angle_i),
    .last_i          (last_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_rec_o         (push_rec)
  );

  lmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rec_o   (pop_rec),
    .empty_o (q_empty)
  );

  lmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (pop_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .direction_o (direction_o),
    .last_res_o  (last_res_o)
  );

endmodule

/* dv/tb_lambda_mst_tangent_2d.sv */
// Testbench for lambda_mst_tangent_2d: loads random curves of points with
// segments, predicts the tangent directions in-line, and checks each result.
// Depends on hdl/lmt_pkg.sv and hdl/lambda_mst_tangent_2d.sv.
`timescale 1ns / 1ps

module tb_lambda_mst_tangent_2d;
  import lmt_pkg::*;

  localparam int WFRAC = 16;

  typedef struct packed {
    logic signed [15:0] direction;
    logic               last_res;
  } dir_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               has_segment_i = 1'b0;
  logic [5:0]         segment_end_i = '0;
  logic signed [15:0] segment_angle_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] direction_o;
  logic               last_res_o;

  dir_res_t   dir_q[$];
  logic       seg_ok_mem[MAX_POINTS];
  logic [5:0] seg_end_mem[MAX_POINTS];
  logic signed [15:0] seg_ang_mem[MAX_POINTS];
  int         pt_cnt;
  int         err_cnt;
  int         idle_pct;
  int         sent_cnt;

  lambda_mst_tangent_2d u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint rdiv(longint a, longint b);
    if (a >= 0) return (a + b / 2) / b;
    return -((-a + b / 2) / b);
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint lam_weight(longint n, longint d);
    longint b, num, den;
    b = d - n;
    num = 64 * n * n * n * b * b * b;
    den = d * d * d * d * d * d;
    return ((num << WFRAC) + den / 2) / den;
  endfunction

  task automatic predict_curve();
    longint wsum[MAX_POINTS];
    longint asum[MAX_POINTS];
    longint dirv[MAX_POINTS];
    longint w, q, nq, prev;
    int n, e;
    dir_res_t r;
    n = pt_cnt;
    for (int k = 0; k < MAX_POINTS; k++) begin
      wsum[k] = 0;
      asum[k] = 0;
      dirv[k] = 0;
    end
    for (int i = 0; i < n; i++) begin
      e = seg_end_mem[i];
      if (seg_ok_mem[i] && e > i) begin
        for (int k = i; k <= e && k < n; k++) begin
          w = lam_weight(k - i, e - i);
          wsum[k] += w;
          asum[k] += w * longint'(seg_ang_mem[i]);
        end
      end
    end
    if (n >= 3) begin
      prev = 0;
      for (int i = 1; i + 1 < n; i++) begin
        if (wsum[i] > 0) begin
          q = rdiv(asum[i], wsum[i]);
        end else begin
          nq = 0;
          if (wsum[i + 1] > 0) nq = rdiv(asum[i + 1], wsum[i + 1]);
          q = rdiv(prev + nq, 2);
        end
        dirv[i] = sat16(q);
        prev = dirv[i];
      end
      dirv[0] = dirv[1];
      dirv[n - 1] = dirv[n - 2];
    end
    for (int k = 0; k < n; k++) begin
      r.direction = 16'(dirv[k]);
      r.last_res = (k == n - 1);
      dir_q.push_back(r);
    end
    pt_cnt = 0;
  endtask

  task automatic send_point(logic hs, logic [5:0] se, logic signed [15:0] ang, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    has_segment_i <= hs;
    segment_end_i <= se;
    segment_angle_i <= ang;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    seg_ok_mem[pt_cnt] = hs;
    seg_end_mem[pt_cnt] = se;
    seg_ang_mem[pt_cnt] = ang;
    pt_cnt++;
    sent_cnt++;
    if (lst || pt_cnt == MAX_POINTS) predict_curve();
  endtask

  // random curve of len points, segments mostly ending 1 to 20 points ahead (at most 63)
  task automatic send_curve(int len, int seg_pct);
    int e;
    for (int i = 0; i < len; i++) begin
      e = i + $urandom_range(20, 1);
      if ($urandom_range(9) == 0) e = $urandom_range(63);
      if (e > 63) e = 63;
      send_point($urandom_range(99) < seg_pct, 6'(e),
                 16'($signed($urandom_range(51472)) - 25736), i == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    dir_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dir_q.size() == 0) begin
        $display("%0t: unexpected result direction=%0d last=%0b",
                 $time, direction_o, last_res_o);
        err_cnt++;
      end else begin
        exp_r = dir_q.pop_front();
        if (exp_r.direction !== direction_o) begin
          $display("%0t: direction expected %0d actual %0d",
                   $time, exp_r.direction, direction_o);
          err_cnt++;
        end
        if (exp_r.last_res !== last_res_o) begin
          $display("%0t: last_res expected %0b actual %0b",
                   $time, exp_r.last_res, last_res_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_point(1'b1, 6'd0, 16'sd0, 1'b1);
    send_point(1'b1, 6'd1, 16'sd25736, 1'b0);
    send_point(1'b0, 6'd63, -16'sd25736, 1'b1);
    send_point(1'b1, 6'd63, 16'sd25736, 1'b0);
    send_point(1'b1, 6'd63, -16'sd25736, 1'b0);
    send_point(1'b1, 6'd3, 16'sd25736, 1'b0);
    send_point(1'b0, 6'd0, 16'sd0, 1'b1);
    send_point(1'b1, 6'd0, 16'sd1000, 1'b0);
    send_point(1'b0, 6'd5, 16'sd1000, 1'b0);
    send_point(1'b1, 6'd2, -16'sd1, 1'b1);
    send_point(1'b1, 6'd2, 16'sd12000, 1'b0);
    send_point(1'b0, 6'd0, 16'sd0, 1'b0);
    send_point(1'b0, 6'd0, 16'sd0, 1'b0);
    send_point(1'b0, 6'd0, 16'sd0, 1'b0);
    send_point(1'b1, 6'd7, -16'sd9000, 1'b0);
    send_point(1'b0, 6'd0, 16'sd0, 1'b1);
  endtask

  task automatic test_long_curve();
    for (int i = 0; i < MAX_POINTS; i++)
      send_point(i % 5 == 0, 6'(i + 6 > 63 ? 63 : i + 6),
                 16'($signed($urandom_range(51472)) - 25736), 1'b0);
  endtask

  task automatic test_random_curves();
    while (sent_cnt < 280) begin
      if ($urandom_range(9) == 0) send_curve($urandom_range(3, 1), 50);
      else send_curve($urandom_range(24, 3), $urandom_range(9) == 0 ? 10 : 60);
    end
  endtask

  initial begin
    err_cnt = 0;
    pt_cnt = 0;
    sent_cnt = 0;
    idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    idle_pct = 36;
    test_long_curve();
    test_random_curves();
    idle_pct = 0;
    send_curve(12, 70);
    in_valid_i <= 1'b0;
    while (dir_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && dir_q.size() == 0)
      $display("** lambda_mst_tangent_2d: PASSED **");
    else
      $display("** lambda_mst_tangent_2d: FAILED **");
    $finish;
  end

  initial begin
    #40ms;
    $display("** lambda_mst_tangent_2d: FAILED **");
    $finish;
  end

endmodule
